>>> src/rhpc_pkg.sv
// shared types, constants and widths for the rgb to hsv pixel converter
package rhpc_pkg;

   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned HUE_W = 9;
   localparam int unsigned PCT_W = 7;

   localparam int unsigned HUE_NUM_W = 14;
   localparam int unsigned SAT_NUM_W = 15;
   localparam int unsigned DIV_W = 15;
   localparam int unsigned QUO_W = 8;
   localparam int unsigned QUO_IDX_W = $clog2(QUO_W);
   localparam int unsigned DIV_BITS_PER_STAGE = 2;
   localparam int unsigned DIV_STAGES = QUO_W / DIV_BITS_PER_STAGE;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [LEVEL_W-1:0] HUE_SCALE = 8'd60;
   localparam logic [LEVEL_W-1:0] PCT_SCALE = 8'd100;
   localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;
   localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 9'd120;
   localparam logic [HUE_W-1:0] HUE_BLUE_BASE = 9'd240;

   typedef enum logic [1:0] {
      SECTOR_GREY,
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      sector_type sector;
      logic hue_neg;
      logic [HUE_NUM_W-1:0] hue_num;
      logic [LEVEL_W-1:0] delta;
      logic [SAT_NUM_W-1:0] sat_num;
      logic [LEVEL_W-1:0] max_level;
      logic [PCT_W-1:0] value_pct;
   } job_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      sector_type sector;
      logic hue_neg;
      logic [LEVEL_W-1:0] delta;
      logic [LEVEL_W-1:0] max_level;
      logic [PCT_W-1:0] value_pct;
      div_lane_type hue;
      div_lane_type sat;
   } stage_type;

   typedef struct packed {
      logic valid;
   } queue_ctl_type;

endpackage

>>> src/rhpc_channels.sv
// pixel and hsv channel interfaces
interface rhpc_pixel_if;
   import rhpc_pkg::*;
   logic valid;
   logic ready;
   logic [LEVEL_W-1:0] red_level;
   logic [LEVEL_W-1:0] green_level;
   logic [LEVEL_W-1:0] blue_level;

   modport source(output valid, output red_level, output green_level, output blue_level,
                  input ready);
   modport sink(input valid, input red_level, input green_level, input blue_level,
                output ready);
endinterface

interface rhpc_hsv_if;
   import rhpc_pkg::*;
   logic valid;
   logic ready;
   logic [HUE_W-1:0] hue_degrees;
   logic [PCT_W-1:0] saturation_pct;
   logic [PCT_W-1:0] value_pct;

   modport source(output valid, output hue_degrees, output saturation_pct,
                  output value_pct, input ready);
   modport sink(input valid, input hue_degrees, input saturation_pct, input value_pct,
                output ready);
endinterface

>>> src/rhpc_front.sv
// front end: max, min, sector and dividends for one pixel
module rhpc_front (
   input  logic [rhpc_pkg::LEVEL_W-1:0] red_level,
   input  logic [rhpc_pkg::LEVEL_W-1:0] green_level,
   input  logic [rhpc_pkg::LEVEL_W-1:0] blue_level,
   output rhpc_pkg::job_type job
);
   import rhpc_pkg::*;

   logic [LEVEL_W-1:0] max_level;
   logic [LEVEL_W-1:0] min_level;
   logic [LEVEL_W-1:0] delta;
   logic [LEVEL_W-1:0] op_a;
   logic [LEVEL_W-1:0] op_b;
   logic [LEVEL_W-1:0] mag;
   logic neg;
   sector_type sector;
   logic [SAT_NUM_W-1:0] value_prod;
   logic [SAT_NUM_W:0] value_sum;

   always_comb begin
      max_level = red_level;
      if (green_level > max_level) max_level = green_level;
      if (blue_level > max_level) max_level = blue_level;
      min_level = red_level;
      if (green_level < min_level) min_level = green_level;
      if (blue_level < min_level) min_level = blue_level;
      delta = max_level - min_level;

      if (delta == '0) begin
         sector = SECTOR_GREY;
      end else if (max_level == red_level) begin
         sector = SECTOR_RED;
      end else if (max_level == green_level) begin
         sector = SECTOR_GREEN;
      end else begin
         sector = SECTOR_BLUE;
      end

      case (sector)
         SECTOR_RED: begin
            op_a = green_level;
            op_b = blue_level;
         end
         SECTOR_GREEN: begin
            op_a = blue_level;
            op_b = red_level;
         end
         SECTOR_BLUE: begin
            op_a = red_level;
            op_b = green_level;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      neg = op_a < op_b;
      mag = neg ? (op_b - op_a) : (op_a - op_b);

      // divide by 255 as (x + 1 + (x >> 8)) >> 8, exact for the 15-bit x used here
      value_prod = SAT_NUM_W'(max_level) * SAT_NUM_W'(PCT_SCALE);
      value_sum = (SAT_NUM_W+1)'(value_prod) + (SAT_NUM_W+1)'(1)
                  + (SAT_NUM_W+1)'(value_prod >> 8);

      job.sector = sector;
      job.hue_neg = neg;
      job.hue_num = HUE_NUM_W'(mag) * HUE_NUM_W'(HUE_SCALE);
      job.delta = delta;
      job.sat_num = SAT_NUM_W'(delta) * SAT_NUM_W'(PCT_SCALE);
      job.max_level = max_level;
      job.value_pct = PCT_W'(value_sum >> 8);
   end

endmodule

>>> src/rhpc_queue.sv
// short queue between front end and divider pipeline
module rhpc_queue #(
   parameter int unsigned DEPTH = rhpc_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  rhpc_pkg::job_type push_data,
   output logic full,
   input  logic pop,
   output rhpc_pkg::queue_ctl_type ctl,
   output rhpc_pkg::job_type pop_data
);
   import rhpc_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign full = count_ff == FULL_CNT;
   assign ctl.valid = count_ff != '0;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop) rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> src/rhpc_back.sv
// back end: pipelined restoring dividers for hue and saturation, result register
module rhpc_back (
   input  logic clock,
   input  logic reset,
   input  rhpc_pkg::queue_ctl_type queue_ctl,
   input  rhpc_pkg::job_type job,
   output logic job_pop,
   rhpc_hsv_if.source rsp
);
   import rhpc_pkg::*;

   function automatic div_lane_type div_steps(input div_lane_type lane,
                                              input logic [LEVEL_W-1:0] divisor,
                                              input int top);
      div_lane_type r;
      logic [DIV_W-1:0] shifted;
      int k;
      r = lane;
      for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
         k = top - j;
         shifted = DIV_W'(divisor) << k;
         if (r.rem >= shifted) begin
            r.rem = r.rem - shifted;
            r.quo[QUO_IDX_W'(k)] = 1'b1;
         end
      end
      return r;
   endfunction

   stage_type stage_ff [DIV_STAGES];
   stage_type stage_in [DIV_STAGES];
   logic [DIV_STAGES-1:0] valid_ff, valid_in;
   logic advance;

   logic out_valid_ff;
   logic [HUE_W-1:0] hue_ff, hue_in;
   logic [PCT_W-1:0] sat_ff, sat_in;
   logic [PCT_W-1:0] value_ff;

   stage_type last;
   logic [HUE_W-1:0] quo9;
   logic [HUE_W-1:0] round_up;

   assign advance = !out_valid_ff || rsp.ready;
   assign job_pop = advance && queue_ctl.valid;

   always_comb begin
      stage_type seed;
      seed.sector = job.sector;
      seed.hue_neg = job.hue_neg;
      seed.delta = job.delta;
      seed.max_level = job.max_level;
      seed.value_pct = job.value_pct;
      seed.hue.rem = DIV_W'(job.hue_num);
      seed.hue.quo = '0;
      seed.sat.rem = DIV_W'(job.sat_num);
      seed.sat.quo = '0;
      stage_in[0] = seed;
      stage_in[0].hue = div_steps(seed.hue, seed.delta, QUO_W - 1);
      stage_in[0].sat = div_steps(seed.sat, seed.max_level, QUO_W - 1);
      valid_in[0] = queue_ctl.valid;
      for (int i = 1; i < DIV_STAGES; i++) begin
         stage_in[i] = stage_ff[i-1];
         stage_in[i].hue = div_steps(stage_ff[i-1].hue, stage_ff[i-1].delta,
                                     QUO_W - 1 - i * DIV_BITS_PER_STAGE);
         stage_in[i].sat = div_steps(stage_ff[i-1].sat, stage_ff[i-1].max_level,
                                     QUO_W - 1 - i * DIV_BITS_PER_STAGE);
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_comb begin
      last = stage_ff[DIV_STAGES-1];
      quo9 = HUE_W'(last.hue.quo);
      round_up = HUE_W'(last.hue.rem != '0);
      case (last.sector)
         SECTOR_RED: hue_in = (last.hue_neg && quo9 != '0) ? HUE_WRAP - quo9 : quo9;
         SECTOR_GREEN: hue_in = last.hue_neg ? HUE_GREEN_BASE - quo9 - round_up
                                             : HUE_GREEN_BASE + quo9;
         SECTOR_BLUE: hue_in = last.hue_neg ? HUE_BLUE_BASE - quo9 - round_up
                                            : HUE_BLUE_BASE + quo9;
         default: hue_in = '0;
      endcase
      sat_in = (last.max_level == '0) ? '0 : PCT_W'(last.sat.quo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
         out_valid_ff <= valid_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < DIV_STAGES; i++) stage_ff[i] <= stage_in[i];
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         value_ff <= last.value_pct;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.hue_degrees = hue_ff;
   assign rsp.saturation_pct = sat_ff;
   assign rsp.value_pct = value_ff;

endmodule

>>> src/rgb_to_hsv_pixel_converter.sv
// top level of the rgb to hsv pixel converter
//
// req carries one 8-bit rgb pixel per transfer, rsp one hsv result per
// transfer (hue in degrees 0..359, saturation and value in percent).
// both channels use valid/ready; a transfer happens when both are high.
// the front end finds max, min, sector and the two dividends in the cycle
// of the req transfer and writes them into a short queue. the back end
// pops the queue into a four-stage divider pipeline that resolves two
// quotient bits per stage for hue and saturation, then a result register.
// a pixel passes the queue, four divider stages and result register to
// rsp. throughput is one pixel per clock while rsp is not stalled; when
// rsp.valid is high and rsp.ready low, the pipeline holds and the queue
// absorbs up to QUEUE_DEPTH further pixels before req.ready drops.
// reset empties the queue and the pipeline; rsp.valid is low after reset.
module rgb_to_hsv_pixel_converter #(
   parameter int unsigned QUEUE_DEPTH = rhpc_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   rhpc_pixel_if.sink req,
   rhpc_hsv_if.source rsp
);
   import rhpc_pkg::*;

   job_type front_job;
   job_type queue_job;
   queue_ctl_type queue_ctl;
   logic queue_full;
   logic job_pop;

   rhpc_front u_front (
      .red_level  (req.red_level),
      .green_level(req.green_level),
      .blue_level (req.blue_level),
      .job        (front_job)
   );

   assign req.ready = !queue_full;

   rhpc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req.valid),
      .push_data(front_job),
      .full     (queue_full),
      .pop      (job_pop),
      .ctl      (queue_ctl),
      .pop_data (queue_job)
   );

   rhpc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .queue_ctl(queue_ctl),
      .job      (queue_job),
      .job_pop  (job_pop),
      .rsp      (rsp)
   );

endmodule
